// File: rtl/core/i2crm_pkg.sv
`timescale 1ns / 1ps
package i2crm_pkg;

    // Command codes of an input transfer.
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SUPPLY = 2'd3
    } t_cmd;

    // Bus sequencer phases, one-hot.
    typedef enum logic [16:0] {
        PH_IDLE      = 17'b00000000000000001,
        PH_ST_HIGH   = 17'b00000000000000010,
        PH_ST_LOW    = 17'b00000000000000100,
        PH_TX_LOW    = 17'b00000000000001000,
        PH_TX_HIGH   = 17'b00000000000010000,
        PH_ACK_REL   = 17'b00000000000100000,
        PH_ACK_HIGH  = 17'b00000000001000000,
        PH_ACK_POLL  = 17'b00000000010000000,
        PH_RS_PREP   = 17'b00000000100000000,
        PH_DATA_LOAD = 17'b00000001000000000,
        PH_RX_LOW    = 17'b00000010000000000,
        PH_RX_HIGH   = 17'b00000100000000000,
        PH_MACK_LOW  = 17'b00001000000000000,
        PH_MACK_HIGH = 17'b00010000000000000,
        PH_STOP_LOW  = 17'b00100000000000000,
        PH_STOP_HIGH = 17'b01000000000000000,
        PH_FINISH    = 17'b10000000000000000
    } t_phase;

    // Which byte of the transaction is on the wire.
    typedef enum logic [1:0] {
        STG_ADDR_W = 2'd0,
        STG_REG    = 2'd1,
        STG_ADDR_R = 2'd2,
        STG_DATA   = 2'd3
    } t_stage;

    // Configuration register indexes.
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] DATA_GAP          = 16'd10;
    localparam int          CHAIN_MAX         = 3;

    // A classified input transfer, as queued between front and back.
    typedef struct packed {
        logic       is_begin;
        logic       is_read;
        logic       is_supply;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_item;

    // One result transfer.
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       need_data;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       done_res;
        logic       error;
    } t_res;

    // Complete sequencer state.
    typedef struct packed {
        t_phase      phase;
        t_stage      stage;
        logic [3:0]  bit_index;
        logic [15:0] dly;
        logic [15:0] poll;
        logic [7:0]  shift;
        logic [7:0]  bytes_left;
        logic [6:0]  addr;
        logic [7:0]  regi;
        logic        is_read;
        logic [7:0]  held_byte;
        logic        held_full;
        logic        scl;
        logic        sda;
        logic        aborted;
        logic        o_valid;
        logic        o_last;
        logic [7:0]  o_byte;
        logic        o_done;
        logic        o_err;
    } t_eng;

    // Sequencer state after reset: idle, both lines released, all else clear.
    localparam t_eng ENG_RESET = '{
        phase   : PH_IDLE,
        stage   : STG_ADDR_W,
        scl     : 1'b1,
        sda     : 1'b1,
        default : '0
    };

endpackage

// File: rtl/core/i2crm_front.sv
`timescale 1ns / 1ps
module i2crm_front
    import i2crm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_command,
    input  logic [6:0] i_slave_address,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_write_byte,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_take,
    output t_item      o_item
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_in;
    logic       w_out;

    // Classify the command on entry.
    always_comb begin
        w_item.is_begin         = (t_cmd'(i_command) == CMD_WRITE) ||
                                  (t_cmd'(i_command) == CMD_READ);
        w_item.is_read          = (t_cmd'(i_command) == CMD_READ);
        w_item.is_supply        = (t_cmd'(i_command) == CMD_SUPPLY);
        w_item.slave_address    = i_slave_address;
        w_item.register_address = i_register_address;
        w_item.byte_count       = i_byte_count;
        w_item.write_byte       = i_write_byte;
        w_item.sda_in           = i_sda_in;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    // Two-entry queue towards the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_mem[r_wr] <= w_item;
                r_wr        <= !r_wr;
            end
            if (w_out) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

endmodule

// File: rtl/core/i2crm_out_queue.sv
`timescale 1ns / 1ps
module i2crm_out_queue
    import i2crm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);

    t_res       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_in;
    logic       w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rd];
    assign w_in    = i_wr && !o_full;
    assign w_out   = i_pop && !o_empty;

    // Two-entry result queue; the sequencer stalls while it is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_mem[r_wr] <= i_res;
                r_wr        <= !r_wr;
            end
            if (w_out) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

endmodule

// File: rtl/core/i2crm_engine.sv
`timescale 1ns / 1ps
module i2crm_engine
    import i2crm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    input  logic        i_out_full,
    output logic        o_wr,
    output t_res        o_res
);

    logic [15:0] r_half_period;
    logic [15:0] r_ack_timeout;
    t_eng        r_st;
    t_eng        n_st;
    t_eng        w_s;
    logic [15:0] w_d;
    logic        w_fire;

    // One bus action; the delay to the next one lands in dly.
    function automatic t_eng act(input t_eng s, input logic sda_in,
                                 input logic [15:0] d, input logic [15:0] tmo);
        t_eng t;
        t = s;
        case (s.phase)
            PH_ST_HIGH: begin
                t.scl = 1'b1; t.sda = 1'b1; t.phase = PH_ST_LOW; t.dly = d;
            end
            PH_ST_LOW: begin
                t.sda = 1'b0; t.bit_index = 4'd0; t.phase = PH_TX_LOW; t.dly = d;
            end
            PH_TX_LOW: begin
                t.scl = 1'b0; t.sda = s.shift[7]; t.phase = PH_TX_HIGH; t.dly = d;
            end
            PH_TX_HIGH: begin
                t.scl = 1'b1;
                t.shift = {s.shift[6:0], 1'b0};
                t.bit_index = s.bit_index + 4'd1;
                t.phase = (t.bit_index >= 4'd8) ? PH_ACK_REL : PH_TX_LOW;
                t.dly = d;
            end
            PH_ACK_REL: begin
                t.scl = 1'b0; t.sda = 1'b1; t.phase = PH_ACK_HIGH; t.dly = d;
            end
            PH_ACK_HIGH: begin
                t.scl = 1'b1; t.poll = tmo; t.phase = PH_ACK_POLL; t.dly = d;
            end
            PH_ACK_POLL: begin
                if (sda_in) begin
                    t.poll = s.poll - 16'd1;
                    if (t.poll == 16'd0) begin
                        t.aborted = 1'b1; t.bytes_left = 8'd0;
                        t.phase = PH_STOP_LOW; t.dly = 16'd0;
                    end else begin
                        t.dly = d;
                    end
                end else begin
                    t.scl = 1'b0;
                    t.dly = 16'd0;
                    case (s.stage)
                        STG_ADDR_W: begin
                            t.shift = s.regi; t.stage = STG_REG;
                            t.bit_index = 4'd0; t.phase = PH_TX_LOW;
                        end
                        STG_REG: begin
                            if (s.is_read) begin
                                t.phase = PH_RS_PREP;
                            end else begin
                                t.phase = (s.bytes_left != 8'd0) ? PH_DATA_LOAD
                                                                 : PH_STOP_LOW;
                            end
                        end
                        STG_ADDR_R: begin
                            if (s.bytes_left != 8'd0) begin
                                t.bit_index = 4'd0; t.shift = 8'd0;
                                t.phase = PH_RX_LOW;
                            end else begin
                                t.phase = PH_STOP_LOW;
                            end
                        end
                        default: begin
                            t.phase = (s.bytes_left != 8'd0) ? PH_DATA_LOAD
                                                             : PH_STOP_LOW;
                            t.dly = DATA_GAP;
                        end
                    endcase
                end
            end
            PH_RS_PREP: begin
                t.scl = 1'b0; t.sda = 1'b1;
                t.shift = {s.addr, 1'b1};
                t.stage = STG_ADDR_R; t.phase = PH_ST_HIGH; t.dly = d;
            end
            PH_DATA_LOAD: begin
                t.scl = 1'b0;
                if (!s.held_full) begin
                    t.dly = 16'd1;
                end else begin
                    t.shift = s.held_byte; t.held_full = 1'b0;
                    t.bytes_left = s.bytes_left - 8'd1;
                    t.stage = STG_DATA; t.bit_index = 4'd0;
                    t.phase = PH_TX_LOW; t.dly = 16'd0;
                end
            end
            PH_RX_LOW: begin
                t.scl = 1'b0; t.sda = 1'b1; t.phase = PH_RX_HIGH; t.dly = d;
            end
            PH_RX_HIGH: begin
                t.scl = 1'b1;
                t.shift = {s.shift[6:0], sda_in};
                t.bit_index = s.bit_index + 4'd1;
                if (t.bit_index >= 4'd8) begin
                    t.bytes_left = s.bytes_left - 8'd1;
                    t.o_valid = 1'b1; t.o_byte = t.shift;
                    t.o_last = (t.bytes_left == 8'd0);
                    t.phase = PH_MACK_LOW;
                end else begin
                    t.phase = PH_RX_LOW;
                end
                t.dly = d;
            end
            PH_MACK_LOW: begin
                t.scl = 1'b0; t.sda = (s.bytes_left == 8'd0);
                t.phase = PH_MACK_HIGH; t.dly = d;
            end
            PH_MACK_HIGH: begin
                t.scl = 1'b1;
                if (s.bytes_left != 8'd0) begin
                    t.bit_index = 4'd0; t.shift = 8'd0; t.phase = PH_RX_LOW;
                end else begin
                    t.phase = PH_STOP_LOW;
                end
                t.dly = d;
            end
            PH_STOP_LOW: begin
                t.scl = 1'b0; t.sda = 1'b0; t.phase = PH_STOP_HIGH; t.dly = d;
            end
            PH_STOP_HIGH: begin
                t.scl = 1'b1; t.sda = 1'b1; t.phase = PH_FINISH; t.dly = d;
            end
            PH_FINISH: begin
                t.o_done = 1'b1; t.o_err = s.aborted; t.phase = PH_IDLE; t.dly = 16'd0;
            end
            default: begin
                t.phase = PH_IDLE; t.dly = 16'd0;
            end
        endcase
        return t;
    endfunction

    assign w_fire = i_valid && !i_out_full;
    assign o_take = w_fire;
    assign o_wr   = w_fire;
    assign w_d    = (r_half_period == 16'd0) ? 16'd1 : r_half_period;

    // One tick: take the command, then run every action that falls due on it.
    always_comb begin
        w_s = r_st;
        w_s.o_valid = 1'b0;
        w_s.o_last  = 1'b0;
        w_s.o_byte  = 8'd0;
        w_s.o_done  = 1'b0;
        w_s.o_err   = 1'b0;
        if (i_item.is_begin && w_s.phase == PH_IDLE) begin
            w_s.addr       = i_item.slave_address;
            w_s.regi       = i_item.register_address;
            w_s.bytes_left = i_item.byte_count;
            w_s.is_read    = i_item.is_read;
            w_s.stage      = STG_ADDR_W;
            w_s.shift      = {i_item.slave_address, 1'b0};
            w_s.bit_index  = 4'd0;
            w_s.aborted    = 1'b0;
            w_s.held_full  = 1'b0;
            w_s.dly        = 16'd0;
            w_s.phase      = PH_ST_HIGH;
        end else if (i_item.is_supply && w_s.phase != PH_IDLE) begin
            w_s.held_byte = i_item.write_byte;
            w_s.held_full = 1'b1;
        end
        if (w_s.phase != PH_IDLE) begin
            if (w_s.dly != 16'd0) begin
                w_s.dly = w_s.dly - 16'd1;
            end
            for (int k = 0; k < CHAIN_MAX; k++) begin
                if (w_s.dly == 16'd0 && w_s.phase != PH_IDLE) begin
                    w_s = act(w_s, i_item.sda_in, w_d, r_ack_timeout);
                end
            end
            if (w_s.phase == PH_IDLE) begin
                w_s.dly = 16'd0;
            end
        end
        n_st = w_fire ? w_s : r_st;
    end

    // Result of the tick.
    always_comb begin
        o_res.scl_release = w_s.scl;
        o_res.sda_release = w_s.sda;
        o_res.busy_res    = (w_s.phase != PH_IDLE);
        o_res.need_data   = (w_s.phase != PH_IDLE) && !w_s.is_read &&
                            (w_s.bytes_left != 8'd0) && !w_s.held_full;
        o_res.read_byte   = w_s.o_byte;
        o_res.read_valid  = w_s.o_valid;
        o_res.read_last   = w_s.o_last;
        o_res.done_res    = w_s.o_done;
        o_res.error       = w_s.o_err;
    end

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
            r_st          <= ENG_RESET;
        end else begin
            r_st <= n_st;
            if (i_cfg_wr_en && i_cfg_index == CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_ACK_TIMEOUT) begin
                r_ack_timeout <= i_cfg_data;
            end
        end
    end

endmodule

// File: rtl/core/i2c_register_master_unit.sv
`timescale 1ns / 1ps
// I2C register master. Each input transfer is one microsecond bus tick that may
// also carry a command: begin write, begin read or supply a write data byte.
// Input channel: push/full; the item is taken when push is high and full low.
// Result channel: empty/pop; exactly one result per input item, in order,
// carrying the SCL/SDA release levels, busy, need-data, any received byte
// and the done/error flags of that tick.
// Configuration: i_cfg_wr_en with index 0 (half period) or 1 (ACK timeout),
// to be written only while no items are in flight; the block does not enforce it.
// Each input transfer is registered in the front queue; the sequencer takes
// the item from there and writes its result into the result queue, from
// whose head it can be popped.
// Throughput: one item per clock cycle while the result queue is not full;
// each sequencer step runs all bus actions due on the same tick.
// Reset clears both queues, releases both bus lines, returns the sequencer to
// idle and restores the half period to 10 and the ACK timeout to 5000.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, and then full rises on the input side; nothing is lost.
module i2c_register_master_unit
    import i2crm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_slave_address,
    input  logic [7:0]  i_register_address,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_write_byte,
    input  logic        i_sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        o_scl_release,
    output logic        o_sda_release,
    output logic        o_busy_res,
    output logic        o_need_data,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_read_last,
    output logic        o_done_res,
    output logic        o_error,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic  w_q_valid;
    logic  w_take;
    t_item w_item;
    logic  w_wr;
    logic  w_out_full;
    t_res  w_res;
    t_res  w_head;

    // Front: accept and classify commands.
    i2crm_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_command          (i_command),
        .i_slave_address    (i_slave_address),
        .i_register_address (i_register_address),
        .i_byte_count       (i_byte_count),
        .i_write_byte       (i_write_byte),
        .i_sda_in           (i_sda_in),
        .o_valid            (w_q_valid),
        .i_take             (w_take),
        .o_item             (w_item)
    );

    // Back: bus sequencer.
    i2crm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_q_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_out_full  (w_out_full),
        .o_wr        (w_wr),
        .o_res       (w_res)
    );

    // Result queue.
    i2crm_out_queue u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_res   (w_res),
        .o_full  (w_out_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_head)
    );

    assign o_scl_release = w_head.scl_release;
    assign o_sda_release = w_head.sda_release;
    assign o_busy_res    = w_head.busy_res;
    assign o_need_data   = w_head.need_data;
    assign o_read_byte   = w_head.read_byte;
    assign o_read_valid  = w_head.read_valid;
    assign o_read_last   = w_head.read_last;
    assign o_done_res    = w_head.done_res;
    assign o_error       = w_head.error;

endmodule
